### rtl/pwed_pkg.sv
// Shared types and constants for the pairwise euclidean distance block.
// Has no dependencies. Used by pairwise_euclidean_distance and its testbench.
package pwed_pkg;

  // default sizes handed to the top-level parameters
  localparam int MAX_NODES_DEF   = 256;
  localparam int MAX_DIMS_DEF    = 64;
  localparam int COORD_WIDTH_DEF = 16;

  // field widths fixed by the interface
  localparam int NODE_W     = 8;
  localparam int DIM_W      = 6;
  localparam int VALUE_W    = 16;
  localparam int DIST_W     = 19;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // status codes
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_RANGE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT  = 1'b1;

  localparam logic [CFG_DATA_W-1:0] NODE_COUNT_RST = 9'd256;
  localparam logic [6:0]            DIM_COUNT_RST  = 7'd1;

  typedef struct packed {
    logic                      req_type;
    logic [NODE_W-1:0]         node_a;
    logic [NODE_W-1:0]         node_b;
    logic [DIM_W-1:0]          dim_index;
    logic signed [VALUE_W-1:0] coord_value;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              status;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_ROOT
  } state_t;

endpackage

### rtl/pwed_isqrt.sv
// Iterative floor square root, one result bit per clock cycle.
// Stand-alone unit, no package dependencies; used by pairwise_euclidean_distance.
module pwed_isqrt #(
  parameter int IN_W = 41
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [IN_W-1:0]         radicand,
  output logic                    done,
  output logic [(IN_W+1)/2-1:0]   root
);

  localparam int RES_W = (IN_W + 1) / 2;
  localparam int RAD_W = 2 * RES_W;
  localparam int REM_W = RES_W + 3;
  localparam int CNT_W = $clog2(RES_W + 1);

  logic [RAD_W-1:0] rad_r,  rad_nxt;
  logic [REM_W-1:0] rem_r,  rem_nxt;
  logic [RES_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic             run_r,  run_nxt;
  logic             done_r, done_nxt;

  logic [REM_W-1:0] rem_cat;
  logic [REM_W-1:0] trial;

  // one restoring step: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_cat  = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = REM_W'({root_r, 2'b01});
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = RAD_W'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(RES_W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_cat >= trial) begin
        rem_nxt  = rem_cat - trial;
        root_nxt = {root_r[RES_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_cat;
        root_nxt = {root_r[RES_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/pairwise_euclidean_distance.sv
// Coordinate store with pairwise euclidean distance queries, top level.
// Depends on pwed_pkg and instantiates pwed_isqrt.
//
// A write transaction stores one coordinate and its result strobes on the
// next cycle; a new transaction can be started in that same cycle. A query
// reads both nodes' coordinates from a dual-read memory, one dimension a
// cycle, squares and sums them through a two-stage pipe, then runs a
// bit-serial square root. busy stays high until the cycle in which the
// result strobes.
// Results strobe on out_valid for one cycle and cannot be held off.
module pairwise_euclidean_distance #(
  parameter int MAX_NODES   = pwed_pkg::MAX_NODES_DEF,
  parameter int MAX_DIMS    = pwed_pkg::MAX_DIMS_DEF,
  parameter int COORD_WIDTH = pwed_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  pwed_pkg::in_t                         in_data,
  output logic                                  out_valid,
  output pwed_pkg::out_t                        out_data,
  input  logic                                  cfg_we,
  input  logic [pwed_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pwed_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DEPTH  = MAX_NODES * MAX_DIMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int KW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int MAG_W  = COORD_WIDTH + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + $clog2(MAX_DIMS + 1);
  localparam int SUMC_W = (SUM_W > 64) ? 64 : SUM_W;
  localparam int EXT_W  = (SUM_W > 64) ? SUM_W : 64;
  localparam int RES_W  = (SUMC_W + 1) / 2;
  localparam int CMP_W  = (RES_W > pwed_pkg::DIST_W) ? RES_W : pwed_pkg::DIST_W;

  // configuration registers
  logic [pwed_pkg::CFG_DATA_W-1:0] node_count_r;
  logic [6:0]                      dim_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= pwed_pkg::NODE_COUNT_RST;
      dim_count_r  <= pwed_pkg::DIM_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwed_pkg::CFG_NODE_COUNT: node_count_r <= cfg_data;
        pwed_pkg::CFG_DIM_COUNT:  dim_count_r  <= cfg_data[6:0];
        default:                  node_count_r <= node_count_r;
      endcase
    end
  end

  // control and pipeline registers
  pwed_pkg::state_t                state_r, state_nxt;
  logic [KW-1:0]                   k_r, k_nxt;
  logic [pwed_pkg::NODE_W-1:0]     na_r, na_nxt;
  logic [pwed_pkg::NODE_W-1:0]     nb_r, nb_nxt;
  logic                            vld1_r, vld2_r;
  logic                            out_valid_r, out_valid_nxt;
  pwed_pkg::out_t                  out_data_r, out_data_nxt;
  logic [COORD_WIDTH-1:0]          rd_a_r, rd_b_r;
  logic [SQ_W-1:0]                 sq_r;
  logic [SUM_W-1:0]                acc_r;

  logic                            accept;
  logic                            na_ok, nb_ok, di_ok, k_last;
  logic                            mem_we, acc_clr;
  logic [ADDR_W-1:0]               waddr, raddr_a, raddr_b;
  logic signed [31:0]              cv_ext;
  logic signed [MAG_W-1:0]         diff;
  logic [MAG_W-1:0]                mag;
  logic [SQ_W-1:0]                 sq;
  logic [EXT_W-1:0]                acc_ext;
  logic [SUMC_W-1:0]               radicand;
  logic                            isq_start, isq_done;
  logic [RES_W-1:0]                isq_root;
  logic [CMP_W-1:0]                root_ext;
  logic [pwed_pkg::DIST_W-1:0]     dist_sat;

  assign accept = start && (state_r == pwed_pkg::ST_IDLE);
  assign busy   = (state_r != pwed_pkg::ST_IDLE);

  // range checks against the configured counts, clamped to the store size
  assign na_ok = (32'(in_data.node_a) < 32'(node_count_r)) && (32'(in_data.node_a) < MAX_NODES);
  assign nb_ok = (32'(in_data.node_b) < 32'(node_count_r)) && (32'(in_data.node_b) < MAX_NODES);
  assign di_ok = (32'(in_data.dim_index) < 32'(dim_count_r))
              && (32'(in_data.dim_index) < MAX_DIMS);
  assign k_last = (32'(k_r) + 32'd1 == 32'(dim_count_r)) || (32'(k_r) + 32'd1 == MAX_DIMS);

  // store addressing: entry node * MAX_DIMS + dim
  assign cv_ext  = 32'(in_data.coord_value);
  assign waddr   = ADDR_W'(32'(in_data.node_a) * MAX_DIMS + 32'(in_data.dim_index));
  assign raddr_a = ADDR_W'(32'(na_r) * MAX_DIMS + 32'(k_r));
  assign raddr_b = ADDR_W'(32'(nb_r) * MAX_DIMS + 32'(k_r));

  // sum clamp before the root, root clamp after it
  assign acc_ext  = EXT_W'(acc_r);
  assign radicand = (acc_ext > EXT_W'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : acc_ext[SUMC_W-1:0];
  assign root_ext = CMP_W'(isq_root);
  assign dist_sat = (root_ext > CMP_W'(pwed_pkg::DIST_MAX)) ? pwed_pkg::DIST_MAX
                                                            : root_ext[pwed_pkg::DIST_W-1:0];

  // next state and result
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    acc_clr       = 1'b0;
    isq_start     = 1'b0;
    unique case (state_r)
      pwed_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.distance = '0;
          out_data_nxt.status   = pwed_pkg::STAT_OK;
          if (in_data.req_type == pwed_pkg::REQ_WRITE) begin
            if (na_ok && di_ok) begin
              mem_we = 1'b1;
            end else begin
              out_data_nxt.status = pwed_pkg::STAT_RANGE;
            end
          end else if (na_ok && nb_ok && (dim_count_r != 7'd0)) begin
            out_valid_nxt = 1'b0;
            acc_clr       = 1'b1;
            na_nxt        = in_data.node_a;
            nb_nxt        = in_data.node_b;
            k_nxt         = '0;
            state_nxt     = pwed_pkg::ST_READ;
          end else begin
            out_data_nxt.status = pwed_pkg::STAT_RANGE;
          end
        end
      end
      pwed_pkg::ST_READ: begin
        if (k_last) begin
          state_nxt = pwed_pkg::ST_DRAIN;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      pwed_pkg::ST_DRAIN: begin
        if (!vld1_r && !vld2_r) begin
          isq_start = 1'b1;
          state_nxt = pwed_pkg::ST_ROOT;
        end
      end
      pwed_pkg::ST_ROOT: begin
        if (isq_done) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.distance = dist_sat;
          out_data_nxt.status   = pwed_pkg::STAT_OK;
          state_nxt             = pwed_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pwed_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pwed_pkg::ST_IDLE;
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld1_r      <= (state_r == pwed_pkg::ST_READ);
      vld2_r      <= vld1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    na_r       <= na_nxt;
    nb_r       <= nb_nxt;
    out_data_r <= out_data_nxt;
  end

  // coordinate store: one write port, two registered read ports
  logic [COORD_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= cv_ext[COORD_WIDTH-1:0];
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  // difference, square, accumulate
  assign diff = $signed({rd_a_r[COORD_WIDTH-1], rd_a_r})
              - $signed({rd_b_r[COORD_WIDTH-1], rd_b_r});
  assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign sq   = mag * mag;

  always_ff @(posedge clk) begin
    sq_r <= sq;
    if (acc_clr) begin
      acc_r <= '0;
    end else if (vld2_r) begin
      acc_r <= acc_r + SUM_W'(sq_r);
    end
  end

  pwed_isqrt #(
    .IN_W (SUMC_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (isq_start),
    .radicand (radicand),
    .done     (isq_done),
    .root     (isq_root)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result only appears once the block is back to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == pwed_pkg::ST_IDLE))
    else $error("result strobe while a query is in progress");

  // an error transaction never carries a distance
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == pwed_pkg::STAT_RANGE)) |-> (out_data_r.distance == '0))
    else $error("out-of-range result with non-zero distance");

  // a write transaction answers on the next cycle
  a_write_next: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.req_type == pwed_pkg::REQ_WRITE)) |=> out_valid_r)
    else $error("write transaction without a result on the next cycle");

  // the root unit only finishes while the controller waits for it
  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    isq_done |-> (state_r == pwed_pkg::ST_ROOT))
    else $error("square root finished outside the root wait");

  // no memory write while a query is reading
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !busy)
    else $error("store written during a query");

endmodule

### dv/pairwise_euclidean_distance_test.sv
// Self-checking testbench for pairwise_euclidean_distance: coordinate writes and
// distance queries against an in-bench predictor, over several register settings.
// Depends on pwed_pkg and the pairwise_euclidean_distance RTL.
module pairwise_euclidean_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STORE_SLOTS = pwed_pkg::MAX_NODES_DEF * pwed_pkg::MAX_DIMS_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          SETTLE_GAP  = 8;
  localparam int          TAIL_GAP    = 100;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           start;
  logic           busy;
  pwed_pkg::in_t  in_data;
  logic           out_valid;
  pwed_pkg::out_t out_data;
  logic           cfg_we;
  logic [pwed_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pwed_pkg::CFG_DATA_W-1:0] cfg_data;

  // predictor state: register copies and coordinate store
  logic [pwed_pkg::CFG_DATA_W-1:0]     node_reg;
  logic [6:0]                          dim_reg;
  logic signed [pwed_pkg::VALUE_W-1:0] coord_copy [STORE_SLOTS];
  bit                                  coord_written [STORE_SLOTS];

  pwed_pkg::out_t pending_results [$];
  pwed_pkg::out_t want_result;
  int unsigned    working_set [$];
  bit             idling_on = 1'b1;

  int unsigned cycle_count = 0;
  int unsigned failures = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned query_count = 0;
  int unsigned reject_count = 0;
  int unsigned cfg_count = 0;

  pairwise_euclidean_distance dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pairwise_euclidean_distance_test: FAIL");
      $finish;
    end
  end

  // effective counts, clamped to the store size
  function automatic int unsigned node_limit();
    return (node_reg > pwed_pkg::MAX_NODES_DEF) ? pwed_pkg::MAX_NODES_DEF : node_reg;
  endfunction

  function automatic int unsigned dim_limit();
    return (dim_reg > pwed_pkg::MAX_DIMS_DEF) ? pwed_pkg::MAX_DIMS_DEF : dim_reg;
  endfunction

  function automatic int unsigned slot_of(int unsigned node, int unsigned dim);
    return node * pwed_pkg::MAX_DIMS_DEF + dim;
  endfunction

  // floor square root by bitwise trial
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // expected result of one transaction; updates the coordinate copy on writes
  function automatic pwed_pkg::out_t distance_result(pwed_pkg::in_t tr);
    pwed_pkg::out_t  res;
    int unsigned     nlim;
    int unsigned     dlim;
    longint unsigned sum;
    longint unsigned root;
    longint          diff;
    res.distance = '0;
    res.status   = pwed_pkg::STAT_OK;
    nlim = node_limit();
    dlim = dim_limit();
    if (tr.req_type == pwed_pkg::REQ_WRITE) begin
      if (tr.node_a >= nlim || tr.dim_index >= dlim) begin
        res.status = pwed_pkg::STAT_RANGE;
      end else begin
        coord_copy[slot_of(tr.node_a, tr.dim_index)]    = tr.coord_value;
        coord_written[slot_of(tr.node_a, tr.dim_index)] = 1'b1;
      end
    end else if (tr.node_a >= nlim || tr.node_b >= nlim || dlim == 0) begin
      res.status = pwed_pkg::STAT_RANGE;
    end else begin
      sum = 0;
      for (int unsigned k = 0; k < dlim; k++) begin
        diff = longint'(coord_copy[slot_of(tr.node_a, k)])
             - longint'(coord_copy[slot_of(tr.node_b, k)]);
        sum += longint'(diff * diff);
      end
      root = root_floor(sum);
      res.distance = (root > pwed_pkg::DIST_MAX) ? pwed_pkg::DIST_MAX
                                                 : root[pwed_pkg::DIST_W-1:0];
      query_count++;
    end
    if (res.status == pwed_pkg::STAT_RANGE) reject_count++;
    return res;
  endfunction

  // every summed dimension of the node has been written
  function automatic bit node_filled(int unsigned node);
    if (node >= node_limit() || dim_limit() == 0) return 1'b0;
    for (int unsigned k = 0; k < dim_limit(); k++)
      if (!coord_written[slot_of(node, k)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [pwed_pkg::VALUE_W-1:0] random_coord();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return raw[pwed_pkg::VALUE_W-1:0];
    endcase
  endfunction

  function automatic pwed_pkg::in_t make_item(logic req, int unsigned a, int unsigned b,
                                              int unsigned d,
                                              logic signed [pwed_pkg::VALUE_W-1:0] v);
    pwed_pkg::in_t tr;
    tr.req_type    = req;
    tr.node_a      = a[pwed_pkg::NODE_W-1:0];
    tr.node_b      = b[pwed_pkg::NODE_W-1:0];
    tr.dim_index   = d[pwed_pkg::DIM_W-1:0];
    tr.coord_value = v;
    return tr;
  endfunction

  // mostly fill-then-query on the working set, the rest random noise
  function automatic pwed_pkg::in_t next_random_item();
    pwed_pkg::in_t tr;
    int unsigned   pick;
    int unsigned   a;
    int unsigned   b;
    int unsigned   d;
    tr = make_item(($urandom_range(1) != 0), $urandom_range(255), $urandom_range(255),
                   $urandom_range(63), random_coord());
    pick = $urandom_range(99);
    if (pick < 12 || working_set.size() == 0) begin
      // never let a query read a coordinate that was not written
      if (tr.req_type == pwed_pkg::REQ_QUERY && tr.node_a < node_limit()
          && tr.node_b < node_limit() && dim_limit() != 0
          && !(node_filled(tr.node_a) && node_filled(tr.node_b)))
        tr.req_type = pwed_pkg::REQ_WRITE;
    end else begin
      a = working_set[$urandom_range(working_set.size() - 1)];
      b = working_set[$urandom_range(working_set.size() - 1)];
      if (pick < 62 && node_filled(a) && node_filled(b)) begin
        tr.req_type = pwed_pkg::REQ_QUERY;
        tr.node_a   = a[pwed_pkg::NODE_W-1:0];
        tr.node_b   = b[pwed_pkg::NODE_W-1:0];
      end else begin
        d = $urandom_range(dim_limit() - 1);
        for (int unsigned k = 0; k < dim_limit(); k++) begin
          if (!coord_written[slot_of(a, k)]) begin
            d = k;
            break;
          end
        end
        tr.req_type  = pwed_pkg::REQ_WRITE;
        tr.node_a    = a[pwed_pkg::NODE_W-1:0];
        tr.dim_index = d[pwed_pkg::DIM_W-1:0];
      end
    end
    return tr;
  endfunction

  // drive one transaction and hold it until the block takes it
  task automatic send_transaction(input pwed_pkg::in_t tr);
    int unsigned gap;
    if (idling_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= tr;
    do @(posedge clk); while (busy);
    pending_results.push_back(distance_result(tr));
    sent_count++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_register(input logic [pwed_pkg::CFG_IDX_W-1:0] idx,
                                input logic [pwed_pkg::CFG_DATA_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == pwed_pkg::CFG_NODE_COUNT) node_reg = value;
    else dim_reg = value[6:0];
    cfg_count++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_phase(input int unsigned nodes, input int unsigned dims,
                                  input int unsigned items, input int unsigned set_size);
    write_register(pwed_pkg::CFG_NODE_COUNT, nodes[pwed_pkg::CFG_DATA_W-1:0]);
    write_register(pwed_pkg::CFG_DIM_COUNT, dims[pwed_pkg::CFG_DATA_W-1:0]);
    working_set.delete();
    if (node_limit() > 0 && dim_limit() > 0) begin
      working_set.push_back(node_limit() - 1);
      while (working_set.size() < set_size)
        working_set.push_back($urandom_range(node_limit() - 1));
    end
    repeat (items) send_transaction(next_random_item());
    wait_idle();
  endtask

  // reset values: node_count 256, one dimension
  task automatic test_reset_values();
    send_transaction(make_item(pwed_pkg::REQ_WRITE, 0, 17, 0, 16'sh8000));
    send_transaction(make_item(pwed_pkg::REQ_WRITE, 255, 0, 0, 16'sh7fff));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 0, 255, 0, 0));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 255, 0, 63, 16'shffff));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 255, 255, 0, 0));
    send_transaction(make_item(pwed_pkg::REQ_WRITE, 3, 0, 1, 16'sh1234));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 0, 0, 63, 16'sh8000));
    wait_idle();
  endtask

  // node and dimension indexes at and beyond the counts
  task automatic test_range_checks();
    write_register(pwed_pkg::CFG_NODE_COUNT, 9'd4);
    write_register(pwed_pkg::CFG_DIM_COUNT, 9'd2);
    send_transaction(make_item(pwed_pkg::REQ_WRITE, 4, 0, 0, 16'sh0001));
    send_transaction(make_item(pwed_pkg::REQ_WRITE, 3, 0, 2, 16'sh0001));
    send_transaction(make_item(pwed_pkg::REQ_WRITE, 3, 0, 0, 16'sh0005));
    send_transaction(make_item(pwed_pkg::REQ_WRITE, 3, 0, 1, -16'sd7));
    send_transaction(make_item(pwed_pkg::REQ_WRITE, 1, 0, 0, -16'sd3));
    send_transaction(make_item(pwed_pkg::REQ_WRITE, 1, 0, 1, 16'sh0001));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 3, 1, 0, 0));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 1, 3, 0, 0));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 3, 4, 0, 0));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 4, 3, 0, 0));
    wait_idle();
  endtask

  // zero node count, then zero dimension count
  task automatic test_zero_counts();
    write_register(pwed_pkg::CFG_NODE_COUNT, 9'd0);
    send_transaction(make_item(pwed_pkg::REQ_WRITE, 0, 0, 0, 16'sh0042));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 0, 0, 0, 0));
    write_register(pwed_pkg::CFG_NODE_COUNT, 9'd256);
    write_register(pwed_pkg::CFG_DIM_COUNT, 9'd0);
    send_transaction(make_item(pwed_pkg::REQ_WRITE, 0, 0, 0, 16'sh0042));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 0, 255, 0, 0));
    wait_idle();
  endtask

  // counts above the store size, all 64 dimensions at opposite extremes
  task automatic test_widest_spread();
    write_register(pwed_pkg::CFG_NODE_COUNT, 9'h1ff);
    write_register(pwed_pkg::CFG_DIM_COUNT, 9'h1ff);
    for (int unsigned k = 0; k < pwed_pkg::MAX_DIMS_DEF; k++) begin
      send_transaction(make_item(pwed_pkg::REQ_WRITE, 0, $urandom_range(255), k, 16'sh8000));
      send_transaction(make_item(pwed_pkg::REQ_WRITE, 255, $urandom_range(255), k, 16'sh7fff));
    end
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 0, 255, 0, 0));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 255, 0, 0, 0));
    send_transaction(make_item(pwed_pkg::REQ_QUERY, 0, 0, 0, 0));
    wait_idle();
  endtask

  task automatic test_random_mix();
    run_random_phase(256, 64, 120, 3);
    run_random_phase(1, 1, 80, 1);
    run_random_phase(5, 3, 150, 5);
    run_random_phase(200, 17, 200, 6);
    run_random_phase(511, 127, 200, 3);
    run_random_phase($urandom_range(1, 511), $urandom_range(1, 127), 200, 4);
  endtask

  // final stretch with start held high whenever possible
  task automatic test_back_to_back();
    idling_on = 1'b0;
    run_random_phase($urandom_range(1, 511), $urandom_range(1, 127), 250, 4);
  endtask

  // result checker: every strobe against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding: distance %0d, status %0d",
               out_data.distance, out_data.status);
        failures++;
      end else begin
        want_result = pending_results.pop_front();
        checked_count++;
        if (out_data.distance !== want_result.distance) begin
          $error("distance mismatch: expected %0d, actual %0d",
                 want_result.distance, out_data.distance);
          failures++;
        end
        if (out_data.status !== want_result.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 want_result.status, out_data.status);
          failures++;
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    node_reg  = pwed_pkg::NODE_COUNT_RST;
    dim_reg   = pwed_pkg::DIM_COUNT_RST;
    for (int i = 0; i < STORE_SLOTS; i++) begin
      coord_copy[i]    = '0;
      coord_written[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_range_checks();
    test_zero_counts();
    test_widest_spread();
    test_random_mix();
    test_back_to_back();

    wait_idle();
    repeat (TAIL_GAP) @(posedge clk);
    $display("covered %0d transactions over %0d register writes: %0d in-range queries, %0d rejects",
             sent_count, cfg_count, query_count, reject_count);
    $display("%0d results checked, %0d mismatches", checked_count, failures);
    if (failures == 0) begin
      $display("pairwise_euclidean_distance_test: PASS");
    end else begin
      $display("pairwise_euclidean_distance_test: FAIL");
    end
    $finish;
  end

endmodule
